[sv/pwmt_pkg.sv]
// ----------------------------------------------------------------------------
// pwmt_pkg
// shared types and constants of the pwm timer with update flag
// ----------------------------------------------------------------------------
`default_nettype none

package pwmt_pkg;

   // field widths of the stream beats
   localparam int unsigned ActionWidth  = 3;
   localparam int unsigned SelectWidth  = 2;
   localparam int unsigned CompareWidth = 16;
   localparam int unsigned PwmWidth     = 4;
   localparam int unsigned CountOutWidth = 16;

   localparam int unsigned ReqUserWidth = ActionWidth + SelectWidth;     // 5
   localparam int unsigned ReqDataWidth = CompareWidth;                  // 16
   localparam int unsigned RspDataWidth = 24;  // 22 bits of fields, padded to bytes

   // configuration port
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PRESCALER = 2'd0,
      CSR_PERIOD    = 2'd1,
      CSR_CHAN_EN   = 2'd2,
      CSR_PRELOAD   = 2'd3
   } csr_index_type;

   // request actions, codes six and seven do nothing
   typedef enum logic [ActionWidth-1:0] {
      ACT_TICK   = 3'd0,
      ACT_START  = 3'd1,
      ACT_STOP   = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_SETCMP = 3'd4,
      ACT_FORCE  = 3'd5
   } action_type;

   // reset values of the configuration registers
   localparam logic [15:0] PrescalerReset = 16'h0000;
   localparam logic [15:0] PeriodReset    = 16'hFFFF;

endpackage

`default_nettype wire

[sv/pwm_timer_with_update_flag.sv]
// ----------------------------------------------------------------------------
// pwm_timer_with_update_flag
// up-counting timer with prescaler, update flag and pwm mode 1 channels
// ----------------------------------------------------------------------------
// path: a request beat passes the input register, then the result register, on its
//   way to its response beat, and is held up only while rsp_tready is low
// throughput: one beat per cycle while rsp_tready does not stall the response; the
//   timer state is updated in a single pass between the input and result registers
// reset: synchronous, active high; clears counters, flag, run state and both
//   compare banks, loads the csr defaults (prescaler 0, period all ones)
`default_nettype none

module pwm_timer_with_update_flag #(
   parameter int unsigned COUNT_WIDTH  = 16,
   parameter int unsigned NUM_CHANNELS = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [pwmt_pkg::ReqDataWidth-1:0]     req_tdata,  // [15:0] compare_value
   input  wire logic [pwmt_pkg::ReqUserWidth-1:0]     req_tuser,  // [2:0] action, [4:3] channel_select
   // response stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [pwmt_pkg::RspDataWidth-1:0]          rsp_tdata,  // [3:0] pwm_out, [4] update_flag,
                                                                  // [20:5] count_value, [21] is_running
   // configuration writes
   input  wire logic                                  csr_we,
   input  wire logic [pwmt_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [pwmt_pkg::CsrDataWidth-1:0]     csr_wdata
);

   import pwmt_pkg::*;

   localparam int unsigned CW   = COUNT_WIDTH;
   // width used to compare the count against a 16 bit compare value
   localparam int unsigned CMPW = (CW > CompareWidth) ? CW : CompareWidth;

   // configuration registers
   logic [15:0] prescaler_ff;
   logic [15:0] period_ff;
   logic [3:0]  chan_en_ff;
   logic        preload_ff;

   // input register
   logic                        in_valid_ff;
   action_type                  in_action_ff;
   logic [SelectWidth-1:0]      in_sel_ff;
   logic [CompareWidth-1:0]     in_value_ff;

   // timer state
   logic [CW-1:0]               presc_cnt_ff, presc_cnt_in;
   logic [CW-1:0]               main_cnt_ff, main_cnt_in;
   logic                        run_ff, run_in;
   logic                        flag_ff, flag_in;
   logic [CompareWidth-1:0]     pend_ff [NUM_CHANNELS];
   logic [CompareWidth-1:0]     pend_in [NUM_CHANNELS];
   logic [CompareWidth-1:0]     act_ff  [NUM_CHANNELS];
   logic [CompareWidth-1:0]     act_in  [NUM_CHANNELS];

   // result register
   logic                        out_valid_ff;
   logic [RspDataWidth-1:0]     out_data_ff;

   logic                        advance;
   logic                        fire;
   logic                        take_req;
   logic                        do_update;
   logic [CW-1:0]               presc_bound;
   logic [CW-1:0]               main_bound;
   logic [PwmWidth-1:0]         pwm_next;

   // pipeline handshake: the result register frees when empty or taken
   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // bounds follow the counter width
   assign presc_bound = CW'(prescaler_ff);
   assign main_bound  = CW'(period_ff);

   // next timer state for the item in the input register
   always_comb begin
      presc_cnt_in = presc_cnt_ff;
      main_cnt_in  = main_cnt_ff;
      run_in       = run_ff;
      flag_in      = flag_ff;
      do_update    = 1'b0;
      pend_in      = pend_ff;
      act_in       = act_ff;
      case (in_action_ff)
         ACT_TICK: begin
            if (run_ff) begin
               if (presc_cnt_ff >= presc_bound) begin
                  presc_cnt_in = '0;
                  // count at or above the period wraps and raises an update
                  if (main_cnt_ff >= main_bound) begin
                     main_cnt_in = '0;
                     do_update   = 1'b1;
                  end else begin
                     main_cnt_in = main_cnt_ff + 1'b1;
                  end
               end else begin
                  presc_cnt_in = presc_cnt_ff + 1'b1;
               end
            end
         end
         ACT_START: run_in  = 1'b1;
         ACT_STOP:  run_in  = 1'b0;
         ACT_CLEAR: flag_in = 1'b0;
         ACT_SETCMP: begin
            // a select beyond the channel count matches nothing
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (in_sel_ff == SelectWidth'(c)) begin
                  pend_in[c] = in_value_ff;
                  if (!preload_ff) begin
                     act_in[c] = in_value_ff;
                  end
               end
            end
         end
         ACT_FORCE: begin
            presc_cnt_in = '0;
            main_cnt_in  = '0;
            do_update    = 1'b1;
         end
         default: ;
      endcase
      // update event: pending compares go live, flag is set
      if (do_update) begin
         flag_in = 1'b1;
         act_in  = pend_ff;
      end
   end

   // pwm mode 1: high while the count is below the active compare
   always_comb begin
      pwm_next = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         pwm_next[c] = chan_en_ff[c] && (CMPW'(main_cnt_in) < CMPW'(act_in[c]));
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= PrescalerReset;
         period_ff    <= PeriodReset;
         chan_en_ff   <= '0;
         preload_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PRESCALER: prescaler_ff <= csr_wdata;
            CSR_PERIOD:    period_ff    <= csr_wdata;
            CSR_CHAN_EN:   chan_en_ff   <= csr_wdata[3:0];
            CSR_PRELOAD:   preload_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_action_ff <= action_type'(req_tuser[ActionWidth-1:0]);
         in_sel_ff    <= req_tuser[ReqUserWidth-1:ActionWidth];
         in_value_ff  <= req_tdata[CompareWidth-1:0];
      end
   end

   // timer state, stepped once per item leaving the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         presc_cnt_ff <= '0;
         main_cnt_ff  <= '0;
         run_ff       <= 1'b0;
         flag_ff      <= 1'b0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            pend_ff[c] <= '0;
            act_ff[c]  <= '0;
         end
      end else if (fire) begin
         presc_cnt_ff <= presc_cnt_in;
         main_cnt_ff  <= main_cnt_in;
         run_ff       <= run_in;
         flag_ff      <= flag_in;
         pend_ff      <= pend_in;
         act_ff       <= act_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= {2'b00, run_in, CountOutWidth'(main_cnt_in), flag_in, pwm_next};
      end
   end

endmodule

`default_nettype wire

[sv/pwmt_checker.sv]
// ----------------------------------------------------------------------------
// pwmt_checker
// port-level checks of the pwm timer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pwmt_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [pwmt_pkg::RspDataWidth-1:0]  rsp_tdata
);

   import pwmt_pkg::*;

   // beats accepted but not yet delivered
   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (!req_beat && rsp_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a response always belongs to an accepted request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 3'd0)
      else $error("response without request");

   // two pipeline registers bound the items in flight
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd2)
      else $error("too many items in flight");

   // padding bits of the response stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataWidth-1:RspDataWidth-2] == 2'b00)
      else $error("response padding not zero");

endmodule

bind pwm_timer_with_update_flag pwmt_checker u_pwmt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
